// ===== rtl/lcb_pkg.sv =====
// ============================================================================
// lcb_pkg
// Types and constants shared by the lamp command and blink controller.
// ============================================================================
`default_nettype none

package lcb_pkg;

   // input item kinds, carried on req_tuser
   localparam logic KIND_COMMAND = 1'b0;
   localparam logic KIND_TICK    = 1'b1;

   // command codes, bits 6..4 of a command byte
   localparam logic [2:0] CMD_GET = 3'd1;
   localparam logic [2:0] CMD_SET = 3'd2;

   // color codes
   localparam logic [2:0] SHADE_DARK  = 3'd0;
   localparam logic [2:0] SHADE_RED   = 3'd1;
   localparam logic [2:0] SHADE_GREEN = 3'd2;

   // reply bytes
   localparam logic [7:0] REPLY_ERROR    = 8'h00;
   localparam logic [7:0] REPLY_SET_OK   = 8'h01;
   localparam logic       REPLY_GET_MARK = 1'b1;

   // register file
   localparam int unsigned  CSR_ADDR_W     = 3;
   localparam logic         REG_TICK_LIMIT = 1'b0;
   localparam logic [14:0]  TICK_LIMIT_RST = 15'd20000;

   typedef struct packed {
      logic       reply_valid;
      logic [7:0] reply_byte;
      logic [7:0] reply_check;
      logic       red_on;
      logic       green_on;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/lcb_csr.sv =====
// ============================================================================
// lcb_csr
// APB-style register file holding the blink tick limit.
// ============================================================================
`default_nettype none

module lcb_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [lcb_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [31:0]                       pwdata,
   output      logic [31:0]                       prdata,
   output      logic                              pready,
   output      logic [14:0]                       tick_limit
);

   logic [14:0] tick_limit_ff;
   logic [14:0] tick_limit_in;
   logic        reg_index;
   logic        wr_en;

   // word index: one register at byte address 0
   assign reg_index = paddr[lcb_pkg::CSR_ADDR_W-1];
   assign wr_en     = psel && penable && pwrite && (reg_index == lcb_pkg::REG_TICK_LIMIT);
   assign pready    = 1'b1;

   always_comb begin
      tick_limit_in = tick_limit_ff;
      if (wr_en) begin
         tick_limit_in = pwdata[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_limit_ff <= lcb_pkg::TICK_LIMIT_RST;
      end else begin
         tick_limit_ff <= tick_limit_in;
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (reg_index == lcb_pkg::REG_TICK_LIMIT) begin
         prdata = {17'd0, tick_limit_ff};
      end
   end

   assign tick_limit = tick_limit_ff;

endmodule

`default_nettype wire

// ===== rtl/lcb_engine.sv =====
// ============================================================================
// lcb_engine
// Controller state and single-pass command / tick evaluation.
// ============================================================================
`default_nettype none

module lcb_engine (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               kind,
   input  wire logic [7:0]         command_byte,
   input  wire logic [14:0]        tick_limit,
   output      lcb_pkg::result_type result
);

   logic [2:0]  color_ff,  color_in;
   logic        blink_ff,  blink_in;
   logic        phase_ff,  phase_in;
   logic [15:0] count_ff,  count_in;
   logic        red_ff,    red_in;
   logic        green_ff,  green_in;

   logic        parity_ok;
   logic [2:0]  cmd;
   logic [15:0] count_inc;
   logic [2:0]  show_color;
   logic [7:0]  reply;

   assign parity_ok = (command_byte[7] == (^command_byte[6:0]));
   assign cmd       = command_byte[6:4];
   assign count_inc = count_ff + 16'd1;

   always_comb begin
      color_in   = color_ff;
      blink_in   = blink_ff;
      phase_in   = phase_ff;
      count_in   = count_ff;
      red_in     = red_ff;
      green_in   = green_ff;
      reply      = lcb_pkg::REPLY_ERROR;
      show_color = lcb_pkg::SHADE_DARK;
      if (kind == lcb_pkg::KIND_COMMAND) begin
         if (parity_ok && (cmd == lcb_pkg::CMD_GET)) begin
            reply = {lcb_pkg::REPLY_GET_MARK, 2'b00, blink_ff, 1'b0, color_ff};
         end else if (parity_ok && (cmd == lcb_pkg::CMD_SET)) begin
            color_in = command_byte[2:0];
            blink_in = command_byte[3];
            reply    = lcb_pkg::REPLY_SET_OK;
         end
      end else begin
         count_in = count_inc;
         if (count_inc > {1'b0, tick_limit}) begin
            count_in = 16'd0;
            phase_in = ~phase_ff;
            // dark during the off phase of a blink
            show_color = (blink_ff && !phase_in) ? lcb_pkg::SHADE_DARK : color_ff;
            red_in     = (show_color == lcb_pkg::SHADE_RED);
            green_in   = (show_color == lcb_pkg::SHADE_GREEN);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= lcb_pkg::SHADE_DARK;
         blink_ff <= 1'b0;
         phase_ff <= 1'b0;
         count_ff <= 16'd0;
         red_ff   <= 1'b0;
         green_ff <= 1'b0;
      end else if (advance) begin
         color_ff <= color_in;
         blink_ff <= blink_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         red_ff   <= red_in;
         green_ff <= green_in;
      end
   end

   always_comb begin
      result.reply_valid = (kind == lcb_pkg::KIND_COMMAND);
      result.reply_byte  = reply;
      result.reply_check = (kind == lcb_pkg::KIND_COMMAND) ? ~reply : 8'h00;
      result.red_on      = red_in;
      result.green_on    = green_in;
   end

endmodule

`default_nettype wire

// ===== rtl/lamp_command_and_blink_controller.sv =====
// ============================================================================
// lamp_command_and_blink_controller
// Red/green lamp controller driven by bus command bytes and timer ticks.
// ============================================================================
// Usage:
//   req_*  : input stream. req_tuser is the kind (0 command byte, 1 timer
//            tick), req_tdata the command byte (parity, command, data).
//   rsp_*  : one result per input transfer, in order. rsp_tuser flags a bus
//            reply; rsp_tdata carries reply byte, its inverse and both lamps.
//   csr_*  : APB-style port, tick_limit at byte address 0. Write it only
//            while no transfer is in flight.
// Path: each input transfer is held in the input register, then its result
//   in the result register, which drives rsp_tvalid. Rate: one transfer per
//   cycle while rsp_tready stays high, as the state update between the two
//   registers is combinational.
// Stall: when the receiver holds rsp_tready low the result register keeps
//   its item and the input register holds the next one; req_tready drops
//   only once both are full, so nothing is lost or repeated.
// Reset: synchronous, active high. Lamps off, no color, blink off, phase
//   and tick counter cleared, tick_limit back to 20000, both stages empty.
// ============================================================================
`default_nettype none

module lamp_command_and_blink_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   // input stream
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] command_byte
   input  wire logic        req_tuser,   // [0] kind
   // result stream
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,   // [7:0] reply_byte, [15:8] reply_check,
                                         // [16] red_on, [17] green_on, rest zero
   output      logic        rsp_tuser,   // [0] reply_valid
   // configuration
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [lcb_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output      logic [31:0]                     csr_prdata,
   output      logic                            csr_pready
);

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_kind_ff;

   // result stage
   logic                out_valid_ff, out_valid_in;
   lcb_pkg::result_type out_ff;

   lcb_pkg::result_type result;
   logic [14:0]         tick_limit;
   logic                advance;
   logic                take_in;

   // the input item moves on when the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take_in    = req_tvalid && req_tready;

   lcb_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .pready     (csr_pready),
      .tick_limit (tick_limit)
   );

   lcb_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .kind         (in_kind_ff),
      .command_byte (in_byte_ff),
      .tick_limit   (tick_limit),
      .result       (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take_in) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (take_in) begin
         in_byte_ff <= req_tdata;
         in_kind_ff <= req_tuser;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.reply_valid;
   assign rsp_tdata  = {6'd0, out_ff.green_on, out_ff.red_on,
                        out_ff.reply_check, out_ff.reply_byte};

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // input side stalls only when both stages hold an item and output stalls
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("req_tready low without a full, stalled pipeline");

   // a bus reply always carries its inverse
   a_reply_check: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[15:8] == ~rsp_tdata[7:0]))
      else $error("reply check byte is not the inverse of the reply");

   // tick results carry no reply bytes
   a_tick_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[15:0] == 16'd0))
      else $error("tick result carries reply bytes");

   // both lamps never lit at once
   a_one_lamp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[16] && rsp_tdata[17]))
      else $error("red and green lamps lit together");

endmodule

`default_nettype wire

// ===== tb/lamp_command_and_blink_controller_tb.sv =====
// ============================================================================
// lamp_command_and_blink_controller_tb
// Self-checking bench for the red/green lamp command and blink controller.
// ----------------------------------------------------------------------------
// Drives command bytes and timer ticks into the request stream, and writes
// and reads back tick_limit between phases over the CSR port. An in-bench
// lamp state tracker predicts every result. Each result transfer is checked
// field by field against the oldest prediction. Both stream sides idle at
// random. At set points the result side holds off for a long stretch, so the
// pipeline backs up into the request side.
// ============================================================================
`timescale 1ns / 1ps

module lamp_command_and_blink_controller_tb;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned ITEMS_PER_PHASE = 135;
   localparam int unsigned LONG_HOLD = 64;       // long result-side back-off
   localparam int unsigned HOLD_SPACING = 700;   // result transfers between back-offs
   localparam int unsigned DRAIN_CYCLES = 4;     // two-stage pipe, plus margin
   localparam logic [lcb_pkg::CSR_ADDR_W-1:0] TICK_LIMIT_ADDR =
      (lcb_pkg::CSR_ADDR_W)'(4 * lcb_pkg::REG_TICK_LIMIT);

   // -------------------------------------------------------------------------
   // Lamp state tracker: mirrors the controller state, keeps the queue of
   // predicted results and checks each result transfer against it.
   // -------------------------------------------------------------------------
   class lamp_state_tracker;
      logic [14:0] tick_limit;
      logic [2:0]  color;
      logic        blink_en;
      logic        phase;
      logic [15:0] tick_count;
      logic        red;
      logic        green;
      lcb_pkg::result_type predicted[$];
      int unsigned errors;

      function void reset_state();
         tick_limit = lcb_pkg::TICK_LIMIT_RST;
         color = lcb_pkg::SHADE_DARK;
         blink_en = 1'b0;
         phase = 1'b0;
         tick_count = '0;
         red = 1'b0;
         green = 1'b0;
         predicted.delete();
         errors = 0;
      endfunction

      function void mismatch(string label, logic [31:0] want, logic [31:0] got);
         errors++;
         $display("%0t: %s expected %0h got %0h", $time, label, want, got);
      endfunction

      function int unsigned pending();
         return predicted.size();
      endfunction

      // one accepted request transfer -> exactly one predicted result
      function void apply_item(logic kind, logic [7:0] cmd_byte);
         lcb_pkg::result_type res;
         logic [7:0]  reply;
         logic [2:0]  shown;
         reply = lcb_pkg::REPLY_ERROR;
         if (kind == lcb_pkg::KIND_TICK) begin
            tick_count = tick_count + 16'd1;
            if (tick_count > {1'b0, tick_limit}) begin
               tick_count = '0;
               phase = ~phase;
               shown = (blink_en && !phase) ? lcb_pkg::SHADE_DARK : color;
               red = (shown == lcb_pkg::SHADE_RED);
               green = (shown == lcb_pkg::SHADE_GREEN);
            end
            res.reply_valid = 1'b0;
            res.reply_byte = '0;
            res.reply_check = '0;
         end else begin
            // bad parity leaves the error reply in place
            if (cmd_byte[7] == ^cmd_byte[6:0]) begin
               if (cmd_byte[6:4] == lcb_pkg::CMD_GET) begin
                  reply = {lcb_pkg::REPLY_GET_MARK, 2'b00, blink_en, 1'b0, color};
               end else if (cmd_byte[6:4] == lcb_pkg::CMD_SET) begin
                  color = cmd_byte[2:0];
                  blink_en = cmd_byte[3];
                  reply = lcb_pkg::REPLY_SET_OK;
               end
            end
            res.reply_valid = 1'b1;
            res.reply_byte = reply;
            res.reply_check = ~reply;
         end
         res.red_on = red;
         res.green_on = green;
         predicted.push_back(res);
      endfunction

      function void check_reply(logic tuser, logic [23:0] tdata);
         lcb_pkg::result_type want;
         if (predicted.size() == 0) begin
            mismatch("unexpected result, tdata", 32'h0, {8'h0, tdata});
            return;
         end
         want = predicted.pop_front();
         if (tuser !== want.reply_valid)
            mismatch("reply_valid", 32'(want.reply_valid), 32'(tuser));
         if (tdata[7:0] !== want.reply_byte)
            mismatch("reply_byte", 32'(want.reply_byte), 32'(tdata[7:0]));
         if (tdata[15:8] !== want.reply_check)
            mismatch("reply_check", 32'(want.reply_check), 32'(tdata[15:8]));
         if (tdata[16] !== want.red_on)
            mismatch("red_on", 32'(want.red_on), 32'(tdata[16]));
         if (tdata[17] !== want.green_on)
            mismatch("green_on", 32'(want.green_on), 32'(tdata[17]));
         if (tdata[23:18] !== 6'd0)
            mismatch("tdata padding", 32'h0, 32'(tdata[23:18]));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] command_byte
   logic        req_tuser;   // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [7:0] reply_byte, [15:8] reply_check, [16] red_on,
                             // [17] green_on, rest zero
   logic        rsp_tuser;   // [0] reply_valid
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [lcb_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]                    csr_pwdata;
   logic [31:0]                    csr_prdata;
   logic                           csr_pready;

   lamp_command_and_blink_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lamp_state_tracker tracker;
   bit          no_idle;          // set for phases that run at full rate
   int unsigned rsp_transfers;
   int unsigned next_hold_at;
   int unsigned cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Request transfers feed the tracker; result transfers get checked. Both
   // sample pre-edge values, so the ordering against the DUT flops is safe.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         tracker.apply_item(req_tuser, req_tdata);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_reply(rsp_tuser, rsp_tdata);
         rsp_transfers++;
      end
   end

   // Gap length: mostly none or short, now and then a long one.
   function automatic int unsigned draw_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Command byte with correct parity in bit 7.
   function automatic logic [7:0] make_command(logic [2:0] cmd, logic [3:0] data);
      return {^{cmd, data}, cmd, data};
   endfunction

   // Result side: random back-pressure, plus a long hold every HOLD_SPACING
   // result transfers so both pipeline stages fill and req_tready drops.
   initial begin
      int unsigned stall;
      rsp_tready = 1'b0;
      next_hold_at = 300;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (rsp_transfers >= next_hold_at) begin
            next_hold_at += HOLD_SPACING;
            rsp_tready = 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else begin
            stall = draw_gap();
            if (stall == 0) begin
               rsp_tready = 1'b1;
            end else begin
               rsp_tready = 1'b0;
               repeat (stall - 1) @(negedge clock);
            end
         end
      end
   end

   // One request transfer, after an optional idle gap. Returns at the edge
   // where the transfer happens; valid stays up until the next negedge.
   task automatic send_item(logic kind, logic [7:0] cmd_byte, int unsigned gap);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = kind;
      req_tdata = cmd_byte;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Wait until every predicted result has come back, then let the pipe settle.
   task automatic wait_drained();
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Two-phase APB access: setup, then access; pready is sampled at the edge.
   task automatic csr_access(logic write, logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = write;
      csr_paddr = TICK_LIMIT_ADDR;
      csr_pwdata = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Only called with the pipeline drained; read back to confirm the write.
   task automatic set_tick_limit(logic [14:0] limit);
      logic [31:0] readback;
      csr_access(1'b1, {17'd0, limit}, readback);
      tracker.tick_limit = limit;
      csr_access(1'b0, 32'd0, readback);
      if (readback !== {17'd0, limit})
         tracker.mismatch("tick_limit readback", {17'd0, limit}, readback);
   endtask

   // Random traffic: mostly well-formed commands and ticks, some raw bytes.
   task automatic random_burst(int unsigned count);
      int unsigned r;
      int unsigned sel;
      logic [2:0]  cmd;
      for (int unsigned i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            send_item(lcb_pkg::KIND_TICK, 8'($urandom_range(0, 255)), draw_gap());
         end else if (r < 88) begin
            sel = $urandom_range(0, 9);
            if (sel < 4)
               cmd = lcb_pkg::CMD_SET;
            else if (sel < 7)
               cmd = lcb_pkg::CMD_GET;
            else
               cmd = 3'($urandom_range(0, 7));
            send_item(lcb_pkg::KIND_COMMAND,
                      make_command(cmd, 4'($urandom_range(0, 15))), draw_gap());
         end else begin
            // raw byte, roughly half with bad parity
            send_item(lcb_pkg::KIND_COMMAND, 8'($urandom_range(0, 255)), draw_gap());
         end
      end
      end_burst();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [14:0] limits[10];
      limits = '{15'd0, 15'd1, 15'd32767, 15'd2, 15'd5, 15'd0, 15'd3,
                 15'd32767, 15'd1, 15'd8};
      tracker = new();
      tracker.reset_state();
      clock = 1'b0;
      reset = 1'b1;
      no_idle = 1'b0;
      rsp_transfers = 0;
      cycles = 0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = lcb_pkg::KIND_COMMAND;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Directed commands at the reset tick_limit: get with nothing stored,
      // command zero, bad parity, the unused commands, a steady red set, a
      // blinking green set, a set of an unknown color, and the all-ones / all-zeros bytes.
      send_item(lcb_pkg::KIND_COMMAND, make_command(lcb_pkg::CMD_GET, 4'h0), 0);
      send_item(lcb_pkg::KIND_COMMAND, make_command(3'd0, 4'h0), 0);
      send_item(lcb_pkg::KIND_COMMAND, make_command(lcb_pkg::CMD_GET, 4'h0) ^ 8'h80, 0);
      for (int c = 3; c < 8; c++)
         send_item(lcb_pkg::KIND_COMMAND, make_command(3'(c), 4'hF), 1);
      send_item(lcb_pkg::KIND_COMMAND,
                make_command(lcb_pkg::CMD_SET, {1'b0, lcb_pkg::SHADE_RED}), 0);
      send_item(lcb_pkg::KIND_COMMAND, make_command(lcb_pkg::CMD_GET, 4'h0), 0);
      send_item(lcb_pkg::KIND_COMMAND,
                make_command(lcb_pkg::CMD_SET, {1'b1, lcb_pkg::SHADE_GREEN}), 0);
      send_item(lcb_pkg::KIND_COMMAND, make_command(lcb_pkg::CMD_GET, 4'h5), 0);
      send_item(lcb_pkg::KIND_COMMAND, make_command(lcb_pkg::CMD_SET, 4'hF), 2);
      send_item(lcb_pkg::KIND_COMMAND, make_command(lcb_pkg::CMD_GET, 4'h0), 0);
      send_item(lcb_pkg::KIND_COMMAND, 8'hFF, 0);
      send_item(lcb_pkg::KIND_COMMAND, 8'h00, 0);
      // a set with bad parity must not touch the stored setting
      send_item(lcb_pkg::KIND_COMMAND, make_command(lcb_pkg::CMD_SET, 4'h1) ^ 8'h80, 0);
      send_item(lcb_pkg::KIND_COMMAND, make_command(lcb_pkg::CMD_GET, 4'h0), 0);
      send_item(lcb_pkg::KIND_TICK, 8'hFF, 0);
      send_item(lcb_pkg::KIND_TICK, 8'h00, 0);
      end_burst();
      wait_drained();

      // Limit zero: every tick toggles the phase. Blinking green goes on
      // and off, steady red stays lit, an unknown color stays dark.
      set_tick_limit(15'd0);
      send_item(lcb_pkg::KIND_COMMAND,
                make_command(lcb_pkg::CMD_SET, {1'b1, lcb_pkg::SHADE_GREEN}), 0);
      send_item(lcb_pkg::KIND_TICK, 8'h00, 0);
      send_item(lcb_pkg::KIND_TICK, 8'h00, 0);
      send_item(lcb_pkg::KIND_TICK, 8'h00, 0);
      send_item(lcb_pkg::KIND_COMMAND,
                make_command(lcb_pkg::CMD_SET, {1'b0, lcb_pkg::SHADE_RED}), 0);
      send_item(lcb_pkg::KIND_TICK, 8'h55, 0);
      send_item(lcb_pkg::KIND_TICK, 8'hAA, 0);
      send_item(lcb_pkg::KIND_COMMAND, make_command(lcb_pkg::CMD_SET, 4'h3), 0);
      send_item(lcb_pkg::KIND_TICK, 8'h00, 0);
      end_burst();
      wait_drained();

      // Random phases over a spread of limits, extremes included; every
      // other phase runs with no idling on either side.
      foreach (limits[p]) begin
         set_tick_limit(limits[p]);
         no_idle = (p % 2 == 1);
         random_burst(ITEMS_PER_PHASE);
         wait_drained();
      end
      no_idle = 1'b0;

      repeat (10) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lcb_pkg.sv
rtl/lcb_csr.sv
rtl/lcb_engine.sv
rtl/lamp_command_and_blink_controller.sv
tb/lamp_command_and_blink_controller_tb.sv
